/* sv/hcp_pkg.sv */
package hcp_pkg;

  localparam int unsigned LETTER_W = 5;
  localparam int unsigned PROD_W   = 10;
  localparam int unsigned SUM_W    = 11;
  localparam int unsigned IDX_W    = 2;

  localparam logic [LETTER_W-1:0] MODULUS = 5'd26;

  localparam logic                OP_ENCRYPT = 1'b0;
  localparam logic                OP_DECRYPT = 1'b1;
  localparam logic                STATUS_OK  = 1'b0;
  localparam logic                STATUS_BAD = 1'b1;

  localparam logic [IDX_W-1:0] REG_KEY_ROW0_COL0 = 2'd0;
  localparam logic [IDX_W-1:0] REG_KEY_ROW0_COL1 = 2'd1;
  localparam logic [IDX_W-1:0] REG_KEY_ROW1_COL0 = 2'd2;
  localparam logic [IDX_W-1:0] REG_KEY_ROW1_COL1 = 2'd3;

  typedef struct packed {
    logic                op;
    logic [LETTER_W-1:0] first_letter;
    logic [LETTER_W-1:0] second_letter;
  } in_item_t;

  typedef struct packed {
    logic [LETTER_W-1:0] out_first;
    logic [LETTER_W-1:0] out_second;
    logic                status;
  } out_item_t;

  typedef struct packed {
    logic [LETTER_W-1:0] k00;
    logic [LETTER_W-1:0] k01;
    logic [LETTER_W-1:0] k10;
    logic [LETTER_W-1:0] k11;
  } key_t;

  // Working matrix plus pair, handed from key derivation to the multiply.
  typedef struct packed {
    logic                bad;
    logic [LETTER_W-1:0] p0;
    logic [LETTER_W-1:0] p1;
    logic [LETTER_W-1:0] m00;
    logic [LETTER_W-1:0] m01;
    logic [LETTER_W-1:0] m10;
    logic [LETTER_W-1:0] m11;
  } mat_item_t;

  // Reduce a 5-bit value that may sit in 26..31.
  function automatic logic [LETTER_W-1:0] red26(input logic [LETTER_W-1:0] x);
    red26 = (x >= MODULUS) ? (x - MODULUS) : x;
  endfunction

  // x mod 26 for x < 2048: reciprocal multiply, then one subtract.
  function automatic logic [LETTER_W-1:0] mod26(input logic [SUM_W-1:0] x);
    logic [22:0]      prod;
    logic [6:0]       q;
    logic [SUM_W-1:0] qm;
    logic [SUM_W-1:0] diff;
    prod  = {12'd0, x} * 23'd2521;
    q     = prod[22:16];
    qm    = {4'd0, q} * 11'd26;
    diff  = x - qm;
    mod26 = diff[LETTER_W-1:0];
  endfunction

  // Inverse modulo 26; 0 where none exists.
  function automatic logic [LETTER_W-1:0] inv26(input logic [LETTER_W-1:0] x);
    case (x)
      5'd1:    inv26 = 5'd1;
      5'd3:    inv26 = 5'd9;
      5'd5:    inv26 = 5'd21;
      5'd7:    inv26 = 5'd15;
      5'd9:    inv26 = 5'd3;
      5'd11:   inv26 = 5'd19;
      5'd15:   inv26 = 5'd7;
      5'd17:   inv26 = 5'd23;
      5'd19:   inv26 = 5'd11;
      5'd21:   inv26 = 5'd5;
      5'd23:   inv26 = 5'd17;
      5'd25:   inv26 = 5'd25;
      default: inv26 = 5'd0;
    endcase
  endfunction

endpackage

/* sv/hill_cipher_pair_transform.sv */
// Channel  Direction  Handshake            Payload
// in       input      in_valid/in_ready    in_item   (op, first_letter, second_letter)
// out      output     out_valid/out_ready  out_item  (out_first, out_second, status)
// cfg      input      cfg_wr_en            cfg_index, cfg_data (key entries 0..3)
//
// One item per cycle unless out_ready stalls. The six register stages form the
// key-inverse and matrix-multiply pipeline (a mod-26 reduction in every second stage).
// Reset clears all stage valid bits and loads the identity key. Such a stall holds a full
// stage only if all later stages are full; empty stages still fill, so bubbles close up.
module hill_cipher_pair_transform (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  hcp_pkg::in_item_t            in_item,
  output logic                         out_valid,
  input  logic                         out_ready,
  output hcp_pkg::out_item_t           out_item,
  input  logic                         cfg_wr_en,
  input  logic [hcp_pkg::IDX_W-1:0]    cfg_index,
  input  logic [hcp_pkg::LETTER_W-1:0] cfg_data
);
  import hcp_pkg::*;

  key_t      key;
  mat_item_t mat;
  logic      mat_valid;
  logic      mat_ready;

  hcp_key_regs u_key_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .key       (key)
  );

  hcp_inv_key u_inv_key (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .key       (key),
    .out_valid (mat_valid),
    .out_ready (mat_ready),
    .out_mat   (mat)
  );

  hcp_mat_mul u_mat_mul (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mat_valid),
    .in_ready  (mat_ready),
    .in_mat    (mat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  a_bad_is_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.status == STATUS_BAD) |->
      (out_item.out_first == 5'd0 && out_item.out_second == 5'd0))
    else $error("non-invertible result carries nonzero letters");

  a_letters_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_item.out_first < MODULUS && out_item.out_second < MODULUS))
    else $error("result letter outside 0..25");

  a_empty_takes_item: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("pipeline refuses an item while its output is empty");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

/* sv/hcp_key_regs.sv */
module hcp_key_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [hcp_pkg::IDX_W-1:0]   cfg_index,
  input  logic [hcp_pkg::LETTER_W-1:0] cfg_data,
  output hcp_pkg::key_t               key
);
  import hcp_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      key.k00 <= 5'd1;
      key.k01 <= 5'd0;
      key.k10 <= 5'd0;
      key.k11 <= 5'd1;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_KEY_ROW0_COL0: key.k00 <= cfg_data;
        REG_KEY_ROW0_COL1: key.k01 <= cfg_data;
        REG_KEY_ROW1_COL0: key.k10 <= cfg_data;
        REG_KEY_ROW1_COL1: key.k11 <= cfg_data;
        default: key <= key;
      endcase
    end
  end

endmodule

/* sv/hcp_inv_key.sv */
module hcp_inv_key (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  hcp_pkg::in_item_t    in_item,
  input  hcp_pkg::key_t        key,
  output logic                 out_valid,
  input  logic                 out_ready,
  output hcp_pkg::mat_item_t   out_mat
);
  import hcp_pkg::*;

  logic [3:0] vld;
  logic [3:0] adv;

  // stage 1: reduced operands and determinant products
  logic                s1_op;
  logic [LETTER_W-1:0] s1_p0, s1_p1;
  key_t                s1_key;
  logic [PROD_W-1:0]   s1_ad, s1_bc;
  key_t                key_red;

  // stage 2: determinant
  logic                s2_op;
  logic [LETTER_W-1:0] s2_p0, s2_p1;
  key_t                s2_key;
  logic [LETTER_W-1:0] s2_det;
  logic [SUM_W-1:0]    det_raw;

  // stage 3: adjugate scaled by the determinant inverse, not yet reduced
  logic                s3_op, s3_bad;
  logic [LETTER_W-1:0] s3_p0, s3_p1;
  key_t                s3_key;
  logic [PROD_W-1:0]   s3_pa, s3_pb, s3_pc, s3_pd;
  logic [LETTER_W-1:0] det_inv, neg_b, neg_c;

  assign adv[3]   = !vld[3] || out_ready;
  assign adv[2]   = !vld[2] || adv[3];
  assign adv[1]   = !vld[1] || adv[2];
  assign adv[0]   = !vld[0] || adv[1];
  assign in_ready = adv[0];
  assign out_valid = vld[3];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) vld[0] <= in_valid;
      if (adv[1]) vld[1] <= vld[0];
      if (adv[2]) vld[2] <= vld[1];
      if (adv[3]) vld[3] <= vld[2];
    end
  end

  always_comb begin
    key_red.k00 = red26(key.k00);
    key_red.k01 = red26(key.k01);
    key_red.k10 = red26(key.k10);
    key_red.k11 = red26(key.k11);
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s1_op  <= in_item.op;
      s1_p0  <= red26(in_item.first_letter);
      s1_p1  <= red26(in_item.second_letter);
      s1_key <= key_red;
      s1_ad  <= {5'd0, key_red.k00} * {5'd0, key_red.k11};
      s1_bc  <= {5'd0, key_red.k01} * {5'd0, key_red.k10};
    end
  end

  // ad - bc made non-negative by adding 26*26
  assign det_raw = {1'b0, s1_ad} + 11'd676 - {1'b0, s1_bc};

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s2_op  <= s1_op;
      s2_p0  <= s1_p0;
      s2_p1  <= s1_p1;
      s2_key <= s1_key;
      s2_det <= mod26(det_raw);
    end
  end

  assign det_inv = inv26(s2_det);
  assign neg_b   = (s2_key.k01 == 5'd0) ? 5'd0 : (MODULUS - s2_key.k01);
  assign neg_c   = (s2_key.k10 == 5'd0) ? 5'd0 : (MODULUS - s2_key.k10);

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      s3_op  <= s2_op;
      s3_p0  <= s2_p0;
      s3_p1  <= s2_p1;
      s3_key <= s2_key;
      // even determinant or 13 has no inverse
      s3_bad <= (s2_op == OP_DECRYPT) && (!s2_det[0] || s2_det == 5'd13);
      s3_pa  <= {5'd0, s2_key.k11} * {5'd0, det_inv};
      s3_pb  <= {5'd0, neg_b} * {5'd0, det_inv};
      s3_pc  <= {5'd0, neg_c} * {5'd0, det_inv};
      s3_pd  <= {5'd0, s2_key.k00} * {5'd0, det_inv};
    end
  end

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      out_mat.bad <= s3_bad;
      out_mat.p0  <= s3_p0;
      out_mat.p1  <= s3_p1;
      if (s3_op == OP_DECRYPT) begin
        out_mat.m00 <= mod26({1'b0, s3_pa});
        out_mat.m01 <= mod26({1'b0, s3_pb});
        out_mat.m10 <= mod26({1'b0, s3_pc});
        out_mat.m11 <= mod26({1'b0, s3_pd});
      end else begin
        out_mat.m00 <= s3_key.k00;
        out_mat.m01 <= s3_key.k01;
        out_mat.m10 <= s3_key.k10;
        out_mat.m11 <= s3_key.k11;
      end
    end
  end

endmodule

/* sv/hcp_mat_mul.sv */
module hcp_mat_mul (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  hcp_pkg::mat_item_t   in_mat,
  output logic                 out_valid,
  input  logic                 out_ready,
  output hcp_pkg::out_item_t   out_item
);
  import hcp_pkg::*;

  logic [1:0] vld;
  logic [1:0] adv;

  logic             s1_bad;
  logic [SUM_W-1:0] s1_sum0, s1_sum1;

  assign adv[1]    = !vld[1] || out_ready;
  assign adv[0]    = !vld[0] || adv[1];
  assign in_ready  = adv[0];
  assign out_valid = vld[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) vld[0] <= in_valid;
      if (adv[1]) vld[1] <= vld[0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s1_bad  <= in_mat.bad;
      s1_sum0 <= {6'd0, in_mat.m00} * {6'd0, in_mat.p0}
               + {6'd0, in_mat.m01} * {6'd0, in_mat.p1};
      s1_sum1 <= {6'd0, in_mat.m10} * {6'd0, in_mat.p0}
               + {6'd0, in_mat.m11} * {6'd0, in_mat.p1};
    end
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      if (s1_bad) begin
        out_item.out_first  <= '0;
        out_item.out_second <= '0;
        out_item.status     <= STATUS_BAD;
      end else begin
        out_item.out_first  <= mod26(s1_sum0);
        out_item.out_second <= mod26(s1_sum1);
        out_item.status     <= STATUS_OK;
      end
    end
  end

endmodule
